[rtl/core/rm_pkg.sv]
// ============================================================================
// rm_pkg
// Shared types for the running median: control that the top level hands to
// each cell of the sorted chain.
// ============================================================================
`default_nettype none

package rm_pkg;

    // Per-cell control from the top level
    typedef struct packed {
        logic load;      // an item is being inserted this cycle
        logic occupied;  // cell lies below the effective fill count
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/core/running_median_top.sv]
// ============================================================================
// running_median_top
// Running median over a signed sample stream, kept in a sorted chain of
// cells that inserts one sample per cycle while no result is stalled.
// ============================================================================
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_ready    i_sample, i_restart
//  result    out        o_out_valid / i_out_ready  o_median, o_count, o_full_res
//
//  One item per cycle sustained while no result stalls; each item passes the
//  insert into the cell chain at the accepting edge, the middle-cell pick and
//  the mean into the output register, in that order.
//  The cell chain inserts at any fill level, all cells updating together.
//  Synchronous active-low reset empties the store (fill count to zero).
//  A stalled result holds the whole pipe, so input is refused until it goes.
// ============================================================================
`default_nettype none

module running_median_top
    import rm_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire                           i_restart,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_median,
    output logic [$clog2(CAPACITY+1)-1:0] o_count,
    output logic                          o_full_res
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                                 w_adv;
    logic                                 w_accept;
    logic [CW-1:0]                        w_cnt_eff;
    logic                                 w_drop;
    logic [CAPACITY-1:0][SAMPLE_BITS-1:0] w_cells;
    logic [CAPACITY-1:0]                  w_take;

    logic [CW-1:0]                        r_count;
    logic [CW-1:0]                        n_count;
    logic                                 r_s1_valid;
    logic [CW-1:0]                        r_s1_count;
    logic                                 r_s1_full;

    // Restart empties the store ahead of this item's sample
    assign w_cnt_eff = i_restart ? '0 : r_count;
    assign w_drop    = (w_cnt_eff == CW'(CAPACITY));
    assign w_accept  = i_in_valid && w_adv;
    assign n_count   = w_drop ? w_cnt_eff : w_cnt_eff + CW'(1);
    assign o_in_ready = w_adv;

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Sorted cell chain
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_cell_ctl                     w_ctl;
        logic signed [SAMPLE_BITS-1:0] w_prev_val;
        logic                          w_prev_take;

        assign w_ctl.load     = w_accept && !w_drop;
        assign w_ctl.occupied = (CW'(gi) < w_cnt_eff);

        if (gi == 0) begin : g_head
            assign w_prev_val  = '0;
            assign w_prev_take = 1'b0;
        end else begin : g_body
            assign w_prev_val  = w_cells[gi-1];
            assign w_prev_take = w_take[gi-1];
        end

        rm_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_sample   (i_sample),
            .i_prev_val (w_prev_val),
            .i_prev_take(w_prev_take),
            .o_val      (w_cells[gi]),
            .o_take     (w_take[gi])
        );
    end

    // Insert stage tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_count <= n_count;
            r_s1_full  <= w_drop;
        end
    end

    rm_median #(
        .CAPACITY   (CAPACITY),
        .SAMPLE_BITS(SAMPLE_BITS),
        .CW         (CW)
    ) u_median (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cells    (w_cells),
        .i_s1_valid (r_s1_valid),
        .i_s1_count (r_s1_count),
        .i_s1_full  (r_s1_full),
        .i_out_ready(i_out_ready),
        .o_adv      (w_adv),
        .o_out_valid(o_out_valid),
        .o_median   (o_median),
        .o_count    (o_count),
        .o_full_res (o_full_res)
    );

    // Fill count stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // A restart item leaves exactly one sample held
    a_restart_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_restart) |=> (r_count == CW'(1)))
        else $error("restart did not leave one sample");

    // A dropped sample leaves the fill count unchanged
    a_drop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_drop) |=> $stable(r_count))
        else $error("dropped sample changed fill count");

    // A full flag is only reported with a full store
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_res) |-> (o_count == CW'(CAPACITY)))
        else $error("full flag with store not full");

endmodule

`default_nettype wire

[rtl/core/rm_cell.sv]
// ============================================================================
// rm_cell
// One cell of the sorted insertion chain. Holds one sample; on an insert it
// either keeps its value, takes its left neighbor's value (shift right), or
// takes the new sample (insertion point).
// ============================================================================
`default_nettype none

module rm_cell
    import rm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                          i_clk,
    input  wire t_cell_ctl               i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_prev_val,
    input  wire logic                    i_prev_take,
    output logic signed [SAMPLE_BITS-1:0] o_val,
    output logic                         o_take
);

    logic signed [SAMPLE_BITS-1:0] r_val;
    logic signed [SAMPLE_BITS-1:0] n_val;

    // Cell moves when empty or holding a value greater than the new sample
    assign o_take = !i_ctl.occupied || (r_val > i_sample);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.load && o_take) begin
            n_val = i_prev_take ? i_prev_val : i_sample;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

[rtl/core/rm_median.sv]
// ============================================================================
// rm_median
// Picks the middle cells of the sorted chain, then forms the median (odd
// count: middle value; even count: truncated mean of the two middle values)
// into the output register.
// ============================================================================
`default_nettype none

module rm_median
    import rm_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int CW          = 7
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire logic [CAPACITY-1:0][SAMPLE_BITS-1:0] i_cells,
    input  wire                                       i_s1_valid,
    input  wire logic [CW-1:0]                        i_s1_count,
    input  wire                                       i_s1_full,
    input  wire                                       i_out_ready,
    output logic                                      o_adv,
    output logic                                      o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]             o_median,
    output logic [CW-1:0]                             o_count,
    output logic                                      o_full_res
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [CW-1:0]                 w_half;
    logic [IW-1:0]                 w_idx_hi;
    logic [IW-1:0]                 w_idx_lo;
    logic signed [SAMPLE_BITS:0]   w_sum;
    logic signed [SAMPLE_BITS:0]   w_rnd;
    logic signed [SAMPLE_BITS:0]   w_avg;

    logic                          r_s2_valid;
    logic signed [SAMPLE_BITS-1:0] r_a;
    logic signed [SAMPLE_BITS-1:0] r_b;
    logic [CW-1:0]                 r_s2_count;
    logic                          r_s2_full;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_median;
    logic [CW-1:0]                 r_count;
    logic                          r_full;

    // Whole pipe moves unless a result is waiting and not taken
    assign o_adv = !r_out_valid || i_out_ready;

    // Middle positions; lower one only used for even counts
    assign w_half   = i_s1_count >> 1;
    assign w_idx_hi = w_half[IW-1:0];
    assign w_idx_lo = IW'(w_half - CW'(1));

    // Pick stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_adv) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_a        <= i_cells[w_idx_hi];
            r_b        <= i_s1_count[0] ? i_cells[w_idx_hi] : i_cells[w_idx_lo];
            r_s2_count <= i_s1_count;
            r_s2_full  <= i_s1_full;
        end
    end

    // Truncating mean: add one to a negative sum before the halving shift
    assign w_sum = {r_a[SAMPLE_BITS-1], r_a} + {r_b[SAMPLE_BITS-1], r_b};
    assign w_rnd = w_sum + {{SAMPLE_BITS{1'b0}}, w_sum[SAMPLE_BITS]};
    assign w_avg = w_rnd >>> 1;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_median <= w_avg[SAMPLE_BITS-1:0];
            r_count  <= r_s2_count;
            r_full   <= r_s2_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;
    assign o_count     = r_count;
    assign o_full_res  = r_full;

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for running_median_top. A behavioral sorted store
// predicts median, count and store-full flag for every accepted item; the
// result checker compares each accepted result with the oldest prediction.
// Runs directed corner cases, a store-fill test, an output hold-off test and
// random sample streams under several idle/stall mixes.
// ============================================================================

module testbench;

    localparam int CAPACITY    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
    localparam int DRAIN_CYCLES = 10;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct {
        t_sample               median;
        logic [COUNT_BITS-1:0] count;
        logic                  full_res;
    } t_median_result;

    // Stream shapes for random samples
    typedef enum int {
        SHAPE_FULL_RANGE,
        SHAPE_NARROW,
        SHAPE_EXTREMES,
        SHAPE_SMALL_SIGNED
    } t_sample_shape;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_sample               i_sample = '0;
    logic                  i_restart = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_sample               o_median;
    logic [COUNT_BITS-1:0] o_count;
    logic                  o_full_res;

    // Predictor state: ascending copy of the held samples
    t_sample        sorted_samples[CAPACITY];
    int             held_samples = 0;
    t_median_result pending_medians[$];

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    running_median_top #(
        .CAPACITY    (CAPACITY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_median    (o_median),
        .o_count     (o_count),
        .o_full_res  (o_full_res)
    );

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #4ms;
        $display("testbench NOT OK");
        $finish;
    end

    // Predict the result of one accepted item
    task automatic predict_median(input t_sample value, input logic restart);
        t_median_result res;
        int pos;
        int half;
        int pair_sum;
        if (restart) held_samples = 0;
        res.full_res = (held_samples >= CAPACITY);
        if (!res.full_res) begin
            pos = 0;
            while (pos < held_samples && sorted_samples[pos] <= value) pos++;
            for (int i = held_samples; i > pos; i--) sorted_samples[i] = sorted_samples[i-1];
            sorted_samples[pos] = value;
            held_samples++;
        end
        half = held_samples / 2;
        if (held_samples % 2 == 1) begin
            res.median = sorted_samples[half];
        end else begin
            // wide sum, then divide truncating toward zero
            pair_sum = int'(sorted_samples[half-1]) + int'(sorted_samples[half]);
            res.median = t_sample'(pair_sum / 2);
        end
        res.count = COUNT_BITS'(held_samples);
        pending_medians.insert(pending_medians.size(), res);
    endtask

    // Offer one item, with random idle cycles ahead of it, until accepted
    task automatic send_item(input t_sample value, input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        i_restart  <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        predict_median(value, restart);
    endtask

    // Drop valid and wait until every predicted result has come
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_sample random_sample(input t_sample_shape shape);
        t_sample v;
        case (shape)
            SHAPE_FULL_RANGE: v = t_sample'($urandom);
            SHAPE_NARROW:     v = t_sample'($urandom_range(8) - 4);
            SHAPE_EXTREMES: begin
                case ($urandom_range(3))
                    0: v = 16'sh8000;
                    1: v = 16'sh8001;
                    2: v = 16'sh7FFE;
                    default: v = 16'sh7FFF;
                endcase
            end
            default:          v = t_sample'($urandom_range(200) - 100);
        endcase
        return v;
    endfunction

    // Receiver: long hold-off on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_median_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_medians.size() == 0) begin
                $display("%0t: unexpected result median=%0d count=%0d full=%0b",
                         $time, o_median, o_count, o_full_res);
                error_count++;
            end else begin
                exp_res = pending_medians.pop_front();
                if (o_median !== exp_res.median) begin
                    $display("%0t: median mismatch expected %0d actual %0d",
                             $time, exp_res.median, o_median);
                    error_count++;
                end
                if (o_count !== exp_res.count) begin
                    $display("%0t: count mismatch expected %0d actual %0d",
                             $time, exp_res.count, o_count);
                    error_count++;
                end
                if (o_full_res !== exp_res.full_res) begin
                    $display("%0t: full_res mismatch expected %0b actual %0b",
                             $time, exp_res.full_res, o_full_res);
                    error_count++;
                end
            end
        end
    end

    // Extremes, rounding of even counts, equal samples
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(16'sd5, 1'b0);          // first item after reset, no restart
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sh7FFF, 1'b0);       // two max values held; the next item gives the wide sum
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sh8000, 1'b1);
        send_item(16'sh8000, 1'b0);       // two min values
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sh7FFF, 1'b0);       // min + max: -1/2 rounds to 0
        send_item(-16'sd3, 1'b1);
        send_item(16'sd0, 1'b0);          // negative odd sum truncates up
        send_item(-16'sd1, 1'b1);
        send_item(16'sd0, 1'b0);
        send_item(16'sd1, 1'b1);
        send_item(16'sd2, 1'b0);
        send_item(16'sd7, 1'b1);
        send_item(16'sd7, 1'b0);          // equal samples
        send_item(16'sd7, 1'b0);
        send_item(16'sh5555, 1'b0);
        send_item(16'shAAAA, 1'b0);
        send_item(16'sh5555, 1'b0);
        send_item(16'shAAAA, 1'b1);
        send_item(16'sh0001, 1'b1);       // restart on a one-item store
        wait_results_drained();
    endtask

    // Fill the store, overflow it, then restart while full
    task automatic test_store_full();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        send_item(random_sample(SHAPE_FULL_RANGE), 1'b1);
        for (int i = 1; i < CAPACITY + 4; i++) begin
            send_item(random_sample(SHAPE_FULL_RANGE), 1'b0);
        end
        send_item(random_sample(SHAPE_FULL_RANGE), 1'b1);
        send_item(random_sample(SHAPE_FULL_RANGE), 1'b0);
        wait_results_drained();
    endtask

    // Long output hold-off while input keeps coming, then a pause to drain
    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 80;
        send_item(random_sample(SHAPE_NARROW), 1'b1);
        for (int i = 0; i < 30; i++) begin
            send_item(random_sample(SHAPE_NARROW), 1'b0);
        end
        wait_results_drained();
    endtask

    // Random streams: each opens with a restart, a few restart mid-stream
    task automatic test_random_streams(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int sent;
        int stream_len;
        t_sample_shape shape;
        sent = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_items) begin
            stream_len = ($urandom_range(9) == 0) ? $urandom_range(60, 72)
                                                  : $urandom_range(1, 20);
            shape = t_sample_shape'($urandom_range(3));
            for (int i = 0; i < stream_len && sent < n_items; i++) begin
                send_item(random_sample(shape), (i == 0) || ($urandom_range(39) == 0));
                sent++;
            end
        end
        wait_results_drained();
    endtask

    // Main sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_store_full();
        test_output_hold();
        test_random_streams(82, 0, 0);
        test_random_streams(82, 68, 0);
        test_random_streams(82, 0, 68);
        test_random_streams(82, 8, 8);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_medians.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_medians.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
